// File: hdl/tasrc_pkg.sv
package tasrc_pkg;

  // Command codes
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_MOVE_ABS = 3'd1;
  localparam logic [2:0] CMD_MOVE_REL = 3'd2;
  localparam logic [2:0] CMD_STOP     = 3'd3;
  localparam logic [2:0] CMD_GET_POS  = 3'd4;
  localparam logic [2:0] CMD_INIT     = 3'd5;
  localparam logic [2:0] CMD_STOP_ALL = 3'd6;

  // Axis codes
  localparam logic [1:0] AXIS_VERT  = 2'd0;
  localparam logic [1:0] AXIS_GRIP  = 2'd1;
  localparam logic [1:0] AXIS_SERVO = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_VERT_LOW   = 3'd0;
  localparam logic [2:0] REG_VERT_HIGH  = 3'd1;
  localparam logic [2:0] REG_GRIP_HIGH  = 3'd2;
  localparam logic [2:0] REG_SERVO_LOW  = 3'd3;
  localparam logic [2:0] REG_SERVO_HIGH = 3'd4;
  localparam logic [2:0] REG_RAMP_TOL   = 3'd5;

  // Configuration reset values
  localparam logic [14:0] RST_VERT_LOW   = 15'd250;
  localparam logic [14:0] RST_VERT_HIGH  = 15'd1420;
  localparam logic [14:0] RST_GRIP_HIGH  = 15'd1530;
  localparam logic [14:0] RST_SERVO_LOW  = 15'd6900;
  localparam logic [14:0] RST_SERVO_HIGH = 15'd31416;
  localparam logic [7:0]  RST_RAMP_TOL   = 8'd10;

  // Position reset values per axis
  localparam logic signed [15:0] HOME_VERT  = 16'sd1420;
  localparam logic signed [15:0] HOME_GRIP  = 16'sd0;
  localparam logic signed [15:0] HOME_SERVO = 16'sd6900;

  // Degrees to 1e-4 rad, scaled by 256
  localparam logic signed [32:0] DEG_SCALE = 33'sd44680;

  // Reciprocal of ten, scaled by 2^19
  localparam logic [31:0] RECIP_TEN = 32'd52429;

  // Replies
  localparam logic [13:0] REPLY_UNINIT  = 14'd9999;
  localparam logic [13:0] REPLY_NEG_ADJ = 14'd5536;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         axis;
    logic signed [15:0] move_value;
    logic signed [15:0] meas_vertical;
    logic signed [15:0] meas_gripper;
    logic signed [15:0] meas_servo;
  } cmd_item_t;

  typedef struct packed {
    logic signed [15:0] setpoint_vertical;
    logic signed [15:0] setpoint_gripper;
    logic signed [15:0] setpoint_servo;
    logic [13:0]        reply_value;
    logic               reply_valid;
  } res_item_t;

  typedef struct packed {
    logic [14:0] vert_low;
    logic [14:0] vert_high;
    logic [14:0] grip_high;
    logic [14:0] servo_low;
    logic [14:0] servo_high;
    logic [7:0]  ramp_tol;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] cur_vert;
    logic signed [15:0] cur_grip;
    logic signed [15:0] cur_servo;
    logic               init_vert;
    logic               init_grip;
  } axis_state_t;

  // Move the setpoint one step toward the target while outside the dead band
  function automatic logic signed [15:0] ramp_step(input logic signed [15:0] sp,
                                                   input logic signed [15:0] tgt,
                                                   input logic [7:0] tol);
    logic signed [16:0] diff;
    logic [16:0]        mag;
    diff = {sp[15], sp} - {tgt[15], tgt};
    mag  = diff[16] ? 17'(-diff) : 17'(diff);
    if (mag > {9'd0, tol}) begin
      ramp_step = diff[16] ? sp + 16'sd1 : sp - 16'sd1;
    end else begin
      ramp_step = sp;
    end
  endfunction

endpackage

// File: hdl/tasrc_cfg_regs.sv
module tasrc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [14:0]   cfg_data,
  output tasrc_pkg::cfg_t cfg
);
  import tasrc_pkg::*;

  // Hold limits and dead band, write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vert_low   <= RST_VERT_LOW;
      cfg.vert_high  <= RST_VERT_HIGH;
      cfg.grip_high  <= RST_GRIP_HIGH;
      cfg.servo_low  <= RST_SERVO_LOW;
      cfg.servo_high <= RST_SERVO_HIGH;
      cfg.ramp_tol   <= RST_RAMP_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERT_LOW:   cfg.vert_low   <= cfg_data;
        REG_VERT_HIGH:  cfg.vert_high  <= cfg_data;
        REG_GRIP_HIGH:  cfg.grip_high  <= cfg_data;
        REG_SERVO_LOW:  cfg.servo_low  <= cfg_data;
        REG_SERVO_HIGH: cfg.servo_high <= cfg_data;
        REG_RAMP_TOL:   cfg.ramp_tol   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/tasrc_reply.sv
module tasrc_reply (
  input  tasrc_pkg::cmd_item_t   item,
  input  tasrc_pkg::axis_state_t status,
  output logic [13:0]            reply_value,
  output logic                   reply_valid
);
  import tasrc_pkg::*;

  logic signed [15:0] lin_pos;
  logic               lin_init;
  logic               lin_neg;
  logic [15:0]        lin_mag;
  logic [31:0]        div_prod;
  logic [12:0]        mm_mag;
  logic [13:0]        lin_reply;
  logic [13:0]        servo_reply;

  // Pick the linear axis being asked about
  assign lin_pos  = (item.axis == AXIS_GRIP) ? status.cur_grip : status.cur_vert;
  assign lin_init = (item.axis == AXIS_GRIP) ? status.init_grip : status.init_vert;

  // Millimetres truncated toward zero, folded into four digits
  assign lin_neg  = lin_pos[15];
  assign lin_mag  = lin_neg ? 16'(-lin_pos) : 16'(lin_pos);
  assign div_prod = 32'(lin_mag) * RECIP_TEN;
  assign mm_mag   = div_prod[31:19];

  always_comb begin
    if (!lin_init) begin
      lin_reply = REPLY_UNINIT;
    end else if (lin_neg && (mm_mag != 13'd0)) begin
      lin_reply = REPLY_NEG_ADJ - {1'b0, mm_mag};
    end else begin
      lin_reply = {1'b0, mm_mag};
    end
  end

  // Whole radians of the servo, negative reads as zero
  always_comb begin
    if (status.cur_servo >= 16'sd30000) begin
      servo_reply = 14'd3;
    end else if (status.cur_servo >= 16'sd20000) begin
      servo_reply = 14'd2;
    end else if (status.cur_servo >= 16'sd10000) begin
      servo_reply = 14'd1;
    end else begin
      servo_reply = 14'd0;
    end
  end

  // Answer only a position request on an existing axis
  always_comb begin
    reply_value = 14'd0;
    reply_valid = 1'b0;
    if (item.command == CMD_GET_POS) begin
      unique case (item.axis) inside
        AXIS_VERT, AXIS_GRIP: begin
          reply_value = lin_reply;
          reply_valid = 1'b1;
        end
        AXIS_SERVO: begin
          reply_value = servo_reply;
          reply_valid = 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/tasrc_core.sv
module tasrc_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  tasrc_pkg::cmd_item_t   item,
  input  tasrc_pkg::cfg_t        cfg,
  output tasrc_pkg::axis_state_t status,
  output logic signed [15:0]     sp_vertical,
  output logic signed [15:0]     sp_gripper,
  output logic signed [15:0]     sp_servo
);
  import tasrc_pkg::*;

  logic signed [15:0] cur_v, cur_g, cur_s;
  logic signed [15:0] tgt_v, tgt_g, tgt_s;
  logic signed [15:0] ramp_v, ramp_g, ramp_s;
  logic               init_v, init_g;

  logic signed [15:0] cur_v_next, cur_g_next, cur_s_next;
  logic signed [15:0] tgt_v_next, tgt_g_next, tgt_s_next;
  logic signed [15:0] ramp_v_next, ramp_g_next, ramp_s_next;
  logic               init_v_next, init_g_next;

  logic signed [19:0] mv_ext, mv_ten, tgt_sel, lin_t;
  logic signed [15:0] vert_t, grip_t, servo_t;
  logic               grip_clip;
  logic signed [32:0] servo_prod;
  logic signed [24:0] servo_raw, servo_hi;

  // Millimetres to 1e-4 m, absolute or added to the present target
  assign mv_ext  = {{4{item.move_value[15]}}, item.move_value};
  assign mv_ten  = (mv_ext <<< 3) + (mv_ext <<< 1);
  assign tgt_sel = (item.axis == AXIS_GRIP) ? {{4{tgt_g[15]}}, tgt_g}
                                            : {{4{tgt_v[15]}}, tgt_v};
  assign lin_t   = (item.command == CMD_MOVE_REL) ? tgt_sel + mv_ten : mv_ten;

  // Clamp the vertical target, low limit checked first
  always_comb begin
    if (lin_t < $signed({5'd0, cfg.vert_low})) begin
      vert_t = $signed({1'b0, cfg.vert_low});
    end else if (lin_t > $signed({5'd0, cfg.vert_high})) begin
      vert_t = $signed({1'b0, cfg.vert_high});
    end else begin
      vert_t = lin_t[15:0];
    end
  end

  // Clamp the gripper target; a clipped move restarts the ramp
  always_comb begin
    grip_clip = 1'b1;
    if (lin_t[19]) begin
      grip_t = 16'sd0;
    end else if (lin_t > $signed({5'd0, cfg.grip_high})) begin
      grip_t = $signed({1'b0, cfg.grip_high});
    end else begin
      grip_t    = lin_t[15:0];
      grip_clip = 1'b0;
    end
  end

  // Degrees to 1e-4 rad with floor, then high and low clamp in that order
  assign servo_prod = 33'(item.move_value) * DEG_SCALE;
  assign servo_raw  = servo_prod[32:8];
  assign servo_hi   = (servo_raw > $signed({10'd0, cfg.servo_high}))
                      ? $signed({10'd0, cfg.servo_high}) : servo_raw;
  assign servo_t    = (servo_hi < $signed({10'd0, cfg.servo_low}))
                      ? $signed({1'b0, cfg.servo_low}) : servo_hi[15:0];

  // Decode the command into the next axis state
  always_comb begin
    cur_v_next  = cur_v;
    cur_g_next  = cur_g;
    cur_s_next  = cur_s;
    tgt_v_next  = tgt_v;
    tgt_g_next  = tgt_g;
    tgt_s_next  = tgt_s;
    ramp_v_next = ramp_v;
    ramp_g_next = ramp_g;
    ramp_s_next = ramp_s;
    init_v_next = init_v;
    init_g_next = init_g;
    unique case (item.command) inside
      CMD_TICK: begin
        cur_v_next  = item.meas_vertical;
        cur_g_next  = item.meas_gripper;
        cur_s_next  = item.meas_servo;
        ramp_v_next = ramp_step(ramp_v, tgt_v, cfg.ramp_tol);
        ramp_g_next = ramp_step(ramp_g, tgt_g, cfg.ramp_tol);
        ramp_s_next = ramp_step(ramp_s, tgt_s, cfg.ramp_tol);
      end
      CMD_MOVE_ABS, CMD_MOVE_REL: begin
        unique case (item.axis)
          AXIS_VERT: tgt_v_next = vert_t;
          AXIS_GRIP: begin
            tgt_g_next = grip_t;
            if (grip_clip) begin
              ramp_g_next = cur_g;
            end
          end
          AXIS_SERVO: begin
            if (item.command == CMD_MOVE_ABS) begin
              tgt_s_next  = servo_t;
              ramp_s_next = cur_s;
            end
          end
          default: ;
        endcase
      end
      CMD_STOP: begin
        unique case (item.axis)
          AXIS_VERT: tgt_v_next = cur_v;
          AXIS_GRIP: begin
            tgt_g_next  = cur_g;
            ramp_g_next = cur_g;
          end
          default: ;
        endcase
      end
      CMD_INIT: begin
        unique case (item.axis)
          AXIS_VERT: begin
            tgt_v_next  = $signed({1'b0, cfg.vert_high});
            init_v_next = 1'b1;
          end
          AXIS_GRIP: begin
            tgt_g_next  = 16'sd0;
            ramp_g_next = cur_g;
            init_g_next = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_STOP_ALL: begin
        tgt_v_next  = cur_v;
        tgt_g_next  = cur_g;
        ramp_g_next = cur_g;
      end
      default: ;
    endcase
  end

  // Hold axis state, advance on each item taken
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v  <= HOME_VERT;
      cur_g  <= HOME_GRIP;
      cur_s  <= HOME_SERVO;
      tgt_v  <= HOME_VERT;
      tgt_g  <= HOME_GRIP;
      tgt_s  <= HOME_SERVO;
      ramp_v <= HOME_VERT;
      ramp_g <= HOME_GRIP;
      ramp_s <= HOME_SERVO;
      init_v <= 1'b0;
      init_g <= 1'b0;
    end else if (go) begin
      cur_v  <= cur_v_next;
      cur_g  <= cur_g_next;
      cur_s  <= cur_s_next;
      tgt_v  <= tgt_v_next;
      tgt_g  <= tgt_g_next;
      tgt_s  <= tgt_s_next;
      ramp_v <= ramp_v_next;
      ramp_g <= ramp_g_next;
      ramp_s <= ramp_s_next;
      init_v <= init_v_next;
      init_g <= init_g_next;
    end
  end

  assign status.cur_vert  = cur_v;
  assign status.cur_grip  = cur_g;
  assign status.cur_servo = cur_s;
  assign status.init_vert = init_v;
  assign status.init_grip = init_g;

  assign sp_vertical = ramp_v_next;
  assign sp_gripper  = ramp_g_next;
  assign sp_servo    = ramp_s_next;

  // Vertical setpoint moves only on a tick
  a_vert_ramp_tick_only: assert property (@(posedge clk) disable iff (rst)
    (go && (item.command != CMD_TICK)) |=> (ramp_v == $past(ramp_v)))
    else $error("vertical setpoint changed outside a tick");

  // Servo setpoint moves only on a tick or an absolute servo move
  a_servo_ramp_src: assert property (@(posedge clk) disable iff (rst)
    (go && (item.command != CMD_TICK) &&
     !((item.command == CMD_MOVE_ABS) && (item.axis == AXIS_SERVO)))
    |=> (ramp_s == $past(ramp_s)))
    else $error("servo setpoint changed unexpectedly");

  // Absolute servo target lands inside consistent limits
  a_servo_clamp: assert property (@(posedge clk) disable iff (rst)
    (go && (item.command == CMD_MOVE_ABS) && (item.axis == AXIS_SERVO) &&
     (cfg.servo_low <= cfg.servo_high))
    |=> ((tgt_s >= $signed({1'b0, $past(cfg.servo_low)})) &&
         (tgt_s <= $signed({1'b0, $past(cfg.servo_high)}))))
    else $error("servo target outside limits");

endmodule

// File: hdl/three_axis_setpoint_ramp_controller.sv
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the receiver takes results; each item gives exactly one result.
// All per-item work is one compare/add/clamp pass, with one constant multiply for the
// servo degree scaling and one for the millimetre reply.
// Reset (rst, synchronous, active high) restores the limit registers, the home
// positions of all axes and clears the initialised flags and both pipeline stages.
module three_axis_setpoint_ramp_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  tasrc_pkg::cmd_item_t cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output tasrc_pkg::res_item_t res,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [14:0]          cfg_data
);
  import tasrc_pkg::*;

  cmd_item_t   in_item;
  logic        in_full;
  logic        go;
  cfg_t        cfg;
  axis_state_t status;
  logic signed [15:0] sp_vertical, sp_gripper, sp_servo;
  logic [13:0] reply_value;
  logic        reply_valid;

  // Advance the held item when the result register is free or being emptied
  assign go        = in_full && (!res_valid || res_ready);
  assign cmd_ready = !in_full || go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_ready) begin
      in_full <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      in_item <= cmd;
    end
  end

  tasrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tasrc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .item        (in_item),
    .cfg         (cfg),
    .status      (status),
    .sp_vertical (sp_vertical),
    .sp_gripper  (sp_gripper),
    .sp_servo    (sp_servo)
  );

  tasrc_reply u_reply (
    .item        (in_item),
    .status      (status),
    .reply_value (reply_value),
    .reply_valid (reply_valid)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res.setpoint_vertical <= sp_vertical;
      res.setpoint_gripper  <= sp_gripper;
      res.setpoint_servo    <= sp_servo;
      res.reply_value       <= reply_value;
      res.reply_valid       <= reply_valid;
    end
  end

  // A reply never exceeds four digits
  a_reply_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.reply_valid) |-> (res.reply_value <= REPLY_UNINIT))
    else $error("reply out of range");

  // No reply means a zero value
  a_reply_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.reply_valid) |-> (res.reply_value == 14'd0))
    else $error("reply value without reply flag");

  // A full input stage that cannot advance blocks new items
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_full && res_valid && !res_ready) |-> !cmd_ready)
    else $error("input accepted while stage blocked");

endmodule

// File: verif/three_axis_setpoint_ramp_controller_test.sv
`timescale 1ns / 100ps

module three_axis_setpoint_ramp_controller_test;
  import tasrc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 100;
  localparam int REPORT_LINES = 40;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  cmd_item_t   cmd       = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_item_t   res;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_VERT_LOW;
  logic [14:0] cfg_data  = '0;

  three_axis_setpoint_ramp_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the limits and of the per-axis positions
  cfg_t limits = '{RST_VERT_LOW, RST_VERT_HIGH, RST_GRIP_HIGH,
                   RST_SERVO_LOW, RST_SERVO_HIGH, RST_RAMP_TOL};
  logic signed [15:0] measured_pos [3] = '{HOME_VERT, HOME_GRIP, HOME_SERVO};
  logic signed [15:0] target_pos   [3] = '{HOME_VERT, HOME_GRIP, HOME_SERVO};
  logic signed [15:0] ramp_pos     [3] = '{HOME_VERT, HOME_GRIP, HOME_SERVO};
  bit                 axis_homed   [2] = '{1'b0, 1'b0};

  res_item_t expected_setpoints [$];
  int        mismatch_count = 0;
  int        results_seen   = 0;
  int        cycle_count    = 0;
  int        burst_left     = 0;
  int        hold_requests  = 0;

  // ---------------------------------------------------------------- predictor

  // Step one LSB toward the target while outside the dead band
  function automatic logic signed [15:0] step_toward(input logic signed [15:0] sp,
                                                     input logic signed [15:0] tgt);
    int gap;
    gap = int'(sp) - int'(tgt);
    if ((gap < 0 ? -gap : gap) > int'(limits.ramp_tol)) begin
      return (gap > 0) ? 16'(sp - 1) : 16'(sp + 1);
    end
    return sp;
  endfunction

  // Clamp a linear target; a clamped gripper restarts its ramp from the measurement
  function automatic void clamp_linear(input logic [1:0] ax, input int t);
    if (ax == AXIS_VERT) begin
      if (t < int'(limits.vert_low)) t = int'(limits.vert_low);
      else if (t > int'(limits.vert_high)) t = int'(limits.vert_high);
      target_pos[AXIS_VERT] = 16'(t);
    end else begin
      if (t < 0) begin
        t = 0;
        ramp_pos[AXIS_GRIP] = measured_pos[AXIS_GRIP];
      end else if (t > int'(limits.grip_high)) begin
        t = int'(limits.grip_high);
        ramp_pos[AXIS_GRIP] = measured_pos[AXIS_GRIP];
      end
      target_pos[AXIS_GRIP] = 16'(t);
    end
  endfunction

  function automatic void stop_vertical();
    target_pos[AXIS_VERT] = measured_pos[AXIS_VERT];
  endfunction

  function automatic void stop_gripper();
    target_pos[AXIS_GRIP] = measured_pos[AXIS_GRIP];
    ramp_pos[AXIS_GRIP]   = measured_pos[AXIS_GRIP];
  endfunction

  // Advance the shadow state by one accepted item and queue its result
  function automatic void predict_setpoints(input cmd_item_t c);
    res_item_t   outcome;
    int          t;
    int          mm;
    logic [13:0] reply;
    logic        valid;
    reply = '0;
    valid = 1'b0;
    case (c.command)
      CMD_TICK: begin
        measured_pos[AXIS_VERT]  = c.meas_vertical;
        measured_pos[AXIS_GRIP]  = c.meas_gripper;
        measured_pos[AXIS_SERVO] = c.meas_servo;
        for (int a = 0; a < 3; a++) ramp_pos[a] = step_toward(ramp_pos[a], target_pos[a]);
      end
      CMD_MOVE_ABS: begin
        if (c.axis == AXIS_VERT || c.axis == AXIS_GRIP) begin
          clamp_linear(c.axis, int'(c.move_value) * 10);
        end else if (c.axis == AXIS_SERVO) begin
          t = (int'(c.move_value) * int'(DEG_SCALE)) >>> 8;
          if (t > int'(limits.servo_high)) t = int'(limits.servo_high);
          if (t < int'(limits.servo_low)) t = int'(limits.servo_low);
          ramp_pos[AXIS_SERVO]   = measured_pos[AXIS_SERVO];
          target_pos[AXIS_SERVO] = 16'(t);
        end
      end
      CMD_MOVE_REL: begin
        if (c.axis == AXIS_VERT || c.axis == AXIS_GRIP) begin
          clamp_linear(c.axis, int'(target_pos[c.axis]) + int'(c.move_value) * 10);
        end
      end
      CMD_STOP: begin
        if (c.axis == AXIS_VERT) stop_vertical();
        else if (c.axis == AXIS_GRIP) stop_gripper();
      end
      CMD_GET_POS: begin
        if (c.axis == AXIS_VERT || c.axis == AXIS_GRIP) begin
          valid = 1'b1;
          if (axis_homed[c.axis]) begin
            mm    = int'(measured_pos[c.axis]) / 10;
            reply = 14'((mm & 32'hFFFF) % 10000);
          end else begin
            reply = REPLY_UNINIT;
          end
        end else if (c.axis == AXIS_SERVO) begin
          valid = 1'b1;
          reply = (measured_pos[AXIS_SERVO] > 0) ?
                  14'(int'(measured_pos[AXIS_SERVO]) / 10000) : 14'd0;
        end
      end
      CMD_INIT: begin
        if (c.axis == AXIS_VERT) begin
          target_pos[AXIS_VERT] = 16'(limits.vert_high);
          axis_homed[AXIS_VERT] = 1'b1;
        end else if (c.axis == AXIS_GRIP) begin
          target_pos[AXIS_GRIP] = '0;
          ramp_pos[AXIS_GRIP]   = measured_pos[AXIS_GRIP];
          axis_homed[AXIS_GRIP] = 1'b1;
        end
      end
      CMD_STOP_ALL: begin
        stop_gripper();
        stop_vertical();
      end
      default: ;
    endcase
    outcome.setpoint_vertical = ramp_pos[AXIS_VERT];
    outcome.setpoint_gripper  = ramp_pos[AXIS_GRIP];
    outcome.setpoint_servo    = ramp_pos[AXIS_SERVO];
    outcome.reply_value       = reply;
    outcome.reply_valid       = valid;
    expected_setpoints.push_back(outcome);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic cmd_item_t make_cmd(input logic [2:0] command, input logic [1:0] ax,
                                         input logic signed [15:0] mv,
                                         input logic signed [15:0] mvert,
                                         input logic signed [15:0] mgrip,
                                         input logic signed [15:0] mservo);
    cmd_item_t c;
    c.command       = command;
    c.axis          = ax;
    c.move_value    = mv;
    c.meas_vertical = mvert;
    c.meas_gripper  = mgrip;
    c.meas_servo    = mservo;
    return c;
  endfunction

  // A measurement close to where the ramp is, so that stops and restarts stay in reach
  function automatic logic signed [15:0] near(input logic signed [15:0] centre,
                                              input int spread);
    int v;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
    return 16'(v);
  endfunction

  // Mostly ticks and plausible moves, with some noise and full-range values
  function automatic cmd_item_t random_command();
    cmd_item_t c;
    int        pick;
    pick            = $urandom_range(0, 99);
    c.axis          = 2'($urandom_range(0, 2));
    c.move_value    = 16'($urandom);
    c.meas_vertical = near(ramp_pos[AXIS_VERT], 30);
    c.meas_gripper  = near(ramp_pos[AXIS_GRIP], 30);
    c.meas_servo    = near(ramp_pos[AXIS_SERVO], 30);
    if (pick < 45) begin
      c.command = CMD_TICK;
    end else if (pick < 60) begin
      c.command = CMD_MOVE_ABS;
      if ($urandom_range(0, 7) != 0) begin
        c.move_value = (c.axis == AXIS_SERVO) ? 16'($urandom_range(0, 200)) :
                       16'(int'($urandom_range(0, 220)) - 20);
      end
    end else if (pick < 70) begin
      c.command = CMD_MOVE_REL;
      if ($urandom_range(0, 7) != 0) c.move_value = 16'(int'($urandom_range(0, 40)) - 20);
    end else if (pick < 77) begin
      c.command = CMD_STOP;
    end else if (pick < 87) begin
      c.command = CMD_GET_POS;
    end else if (pick < 91) begin
      c.command = CMD_INIT;
    end else if (pick < 94) begin
      c.command = CMD_STOP_ALL;
    end else begin
      c = cmd_item_t'({$urandom, $urandom, $urandom});
    end
    return c;
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_cmd(input cmd_item_t item);
    @(negedge clk);
    cmd       <= item;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    predict_setpoints(item);
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic send_paced(input cmd_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        cmd_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_cmd(item);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_paced(random_command());
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_setpoints.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [14:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    case (index)
      REG_VERT_LOW:   limits.vert_low   = data;
      REG_VERT_HIGH:  limits.vert_high  = data;
      REG_GRIP_HIGH:  limits.grip_high  = data;
      REG_SERVO_LOW:  limits.servo_low  = data;
      REG_SERVO_HIGH: limits.servo_high = data;
      REG_RAMP_TOL:   limits.ramp_tol   = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_limits(input logic [14:0] vlow, input logic [14:0] vhigh,
                              input logic [14:0] ghigh, input logic [14:0] slow,
                              input logic [14:0] shigh, input logic [7:0] tol);
    wait_idle();
    write_register(REG_VERT_LOW, vlow);
    write_register(REG_VERT_HIGH, vhigh);
    write_register(REG_GRIP_HIGH, ghigh);
    write_register(REG_SERVO_LOW, slow);
    write_register(REG_SERVO_HIGH, shigh);
    write_register(REG_RAMP_TOL, {7'd0, tol});
  endtask

  // ---------------------------------------------------------------- tests

  // Every command, the uninitialised replies, clamps at both ends and the no-op cases
  task automatic test_directed_commands();
    send_paced(make_cmd(CMD_GET_POS, AXIS_VERT, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_GET_POS, AXIS_GRIP, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_GET_POS, AXIS_SERVO, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_TICK, AXIS_VERT, 0, -32768, 32767, -32768));
    send_paced(make_cmd(CMD_GET_POS, AXIS_SERVO, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_INIT, AXIS_VERT, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_INIT, AXIS_GRIP, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_GET_POS, AXIS_VERT, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_GET_POS, AXIS_GRIP, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_TICK, AXIS_SERVO, -1, 32767, -32768, 32767));
    send_paced(make_cmd(CMD_GET_POS, AXIS_SERVO, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_ABS, AXIS_VERT, 32767, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_ABS, AXIS_VERT, -32768, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_ABS, AXIS_GRIP, -32768, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_ABS, AXIS_GRIP, 32767, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_ABS, AXIS_SERVO, 32767, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_ABS, AXIS_SERVO, -32768, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_REL, AXIS_VERT, 5, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_REL, AXIS_GRIP, -3, 0, 0, 0));
    send_paced(make_cmd(CMD_MOVE_REL, AXIS_SERVO, 40, 0, 0, 0));
    send_paced(make_cmd(CMD_STOP, AXIS_SERVO, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_INIT, AXIS_SERVO, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_STOP_ALL, 2'd3, 0, 0, 0, 0));
    send_paced(make_cmd(CMD_GET_POS, 2'd3, 0, 0, 0, 0));
    send_paced(make_cmd(3'd7, 2'd3, -1, -1, -1, -1));
  endtask

  task automatic test_default_limits();
    send_random(120);
  endtask

  // Hold the receiver off for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_requests++;
    repeat (40) send_cmd(random_command());
  endtask

  task automatic test_zero_limits();
    apply_limits(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 8'd0);
    send_random(40);
  endtask

  task automatic test_full_limits();
    apply_limits(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 8'hFF);
    send_random(40);
  endtask

  task automatic test_inverted_vertical_limits();
    apply_limits(15'd2000, 15'd500, 15'd1000, 15'd20000, 15'd3000, 8'd1);
    send_random(40);
  endtask

  task automatic test_random_limits();
    logic [14:0] vlow;
    logic [14:0] slow;
    repeat (3) begin
      vlow = 15'($urandom_range(0, 2000));
      slow = 15'($urandom_range(0, 10000));
      apply_limits(vlow, 15'($urandom_range(vlow, 4000)), 15'($urandom_range(0, 4000)),
                   slow, 15'($urandom_range(slow, 32767)), 8'($urandom_range(0, 30)));
      send_random(60);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // Stall on a pattern of modes; serve long hold-offs on request
  int rx_mode      = 0;
  int rx_left      = 0;
  int hold_left    = 0;
  int holds_served = 0;

  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_mode)
        0:       res_ready <= 1'b1;
        1:       res_ready <= 1'($urandom_range(0, 1));
        default: res_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) begin
      $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
    end
  endtask

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_setpoints.size() == 0) begin
        report_mismatch("unexpected result, setpoint_vertical", int'(res.setpoint_vertical), 0);
      end else begin
        want = expected_setpoints.pop_front();
        if (res.setpoint_vertical !== want.setpoint_vertical)
          report_mismatch("setpoint_vertical", int'(res.setpoint_vertical),
                          int'(want.setpoint_vertical));
        if (res.setpoint_gripper !== want.setpoint_gripper)
          report_mismatch("setpoint_gripper", int'(res.setpoint_gripper),
                          int'(want.setpoint_gripper));
        if (res.setpoint_servo !== want.setpoint_servo)
          report_mismatch("setpoint_servo", int'(res.setpoint_servo),
                          int'(want.setpoint_servo));
        if (res.reply_value !== want.reply_value)
          report_mismatch("reply_value", int'(res.reply_value), int'(want.reply_value));
        if (res.reply_valid !== want.reply_valid)
          report_mismatch("reply_valid", int'(res.reply_valid), int'(want.reply_valid));
      end
      results_seen++;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_setpoints.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_default_limits();
    test_backpressure();
    test_zero_limits();
    test_full_limits();
    test_inverted_vertical_limits();
    test_random_limits();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
